// ===== src/hildreth_qp_dual_solver_unit_defines.svh =====
// assertion macros for the hildreth qp dual solver unit
`ifndef HILDRETH_QP_DUAL_SOLVER_UNIT_DEFINES_SVH
`define HILDRETH_QP_DUAL_SOLVER_UNIT_DEFINES_SVH

// same-cycle implication
`define HQP_ASSERT_NOW(lbl, clk, rst_n, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

// next-cycle implication
`define HQP_ASSERT_NEXT(lbl, clk, rst_n, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

`endif

// ===== src/hqp_pkg.sv =====
// shared constants, types and fixed-point helpers of the hildreth qp dual solver
package hqp_pkg;

	localparam int DEF_MAX_CONSTRAINTS = 32;
	localparam int DEF_FRAC_BITS       = 16;

	localparam logic [1:0] OP_WR_MATRIX = 2'd0;
	localparam logic [1:0] OP_WR_OFFSET = 2'd1;
	localparam logic [1:0] OP_SOLVE     = 2'd2;

	localparam logic [1:0] REG_ACTIVE_SIZE = 2'd0;
	localparam logic [1:0] REG_MAX_ITER    = 2'd1;
	localparam logic [1:0] REG_TOLERANCE   = 2'd2;
	localparam logic [1:0] REG_FIXED_MODE  = 2'd3;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_CLR  = 10'b00_0000_0010,
		ST_ROW  = 10'b00_0000_0100,
		ST_DR1  = 10'b00_0000_1000,
		ST_DR2  = 10'b00_0001_0000,
		ST_FADD = 10'b00_0010_0000,
		ST_FMUL = 10'b00_0100_0000,
		ST_FWR  = 10'b00_1000_0000,
		ST_ORD  = 10'b01_0000_0000,
		ST_OWT  = 10'b10_0000_0000
	} state_t;

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		if (s[32] != s[31])
			sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		else
			sat_add = s[31:0];
	endfunction

	function automatic logic signed [31:0] fx_scale(input logic signed [63:0] p,
			input int frac);
		logic signed [63:0] q;
		q = p >>> frac;
		if (q > 64'sh0000_0000_7fff_ffff)
			fx_scale = 32'sh7fff_ffff;
		else if (q < -64'sh0000_0000_8000_0000)
			fx_scale = 32'sh8000_0000;
		else
			fx_scale = q[31:0];
	endfunction

endpackage

// ===== src/hildreth_qp_dual_solver_unit.sv =====
// top level of the hildreth qp dual solver: load, gauss-seidel sweeps, result stream
// Load beats (matrix or offset entry) are taken one per cycle while the unit
// is idle. A solve beat clears the N multipliers, then runs sweeps; each row
// streams one matrix row and the multiplier memory through a single 32x32
// multiplier and a saturating accumulator. Results then leave one beat at a
// time, each held until taken; once the last is registered the input is ready
// again. Input is stalled for the whole solve.
module hildreth_qp_dual_solver_unit
	import hqp_pkg::*;
#(
	parameter int MAX_CONSTRAINTS = DEF_MAX_CONSTRAINTS,
	parameter int FRAC_BITS       = DEF_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_en,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // row, col, value
	input  logic [1:0]  s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // index, lambda_value, iterations
	output logic        m_tlast
);

	localparam int IW  = (MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1;
	localparam int CW  = $clog2(MAX_CONSTRAINTS + 1);
	localparam int MD  = MAX_CONSTRAINTS * MAX_CONSTRAINTS;
	localparam int MAW = (MD > 1) ? $clog2(MD) : 1;

	logic [5:0]  active_size_q;
	logic [15:0] max_iter_q;
	logic [30:0] tolerance_q;
	logic        fixed_mode_q;

	logic signed [31:0] matrix_mem [MD];
	logic signed [31:0] offset_mem [MAX_CONSTRAINTS];
	logic signed [31:0] lambda_mem [MAX_CONSTRAINTS];

	state_t state_q;
	logic [CW-1:0] n_q, i_q, j_q;
	logic [15:0]   sweep_q;
	logic          nc_q;

	logic [1:0]         in_op;
	logic [4:0]         in_row, in_col;
	logic signed [31:0] in_value;
	logic               in_beat;

	logic signed [31:0] h_rd, off_rd, lam_rd;
	logic               v_s1, diag_s1, v_s2, skip_s2;
	logic               skip_s1;
	logic signed [63:0] prod_s2;
	logic signed [31:0] acc_q, hdiag_q, old_q, sum_q;

	logic [MAW-1:0]     m_waddr, m_raddr;
	logic [IW-1:0]      lam_raddr;
	logic               lam_we;
	logic [IW-1:0]      lam_waddr;
	logic signed [31:0] lam_wdata;

	logic signed [31:0] mul_a, mul_b;
	logic signed [31:0] nv;
	logic [31:0]        diff;
	logic               diff_big;
	logic [CW-1:0]      n_new;
	logic [15:0]        sweep_inc;

	assign in_op    = s_tuser;
	assign in_row   = s_tdata[4:0];
	assign in_col   = s_tdata[9:5];
	assign in_value = s_tdata[41:10];
	assign s_tready = (state_q == ST_IDLE);
	assign in_beat  = s_tvalid && s_tready;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_size_q <= 6'd32;
			max_iter_q    <= 16'd20;
			tolerance_q   <= 31'd66;
			fixed_mode_q  <= 1'b0;
		end else if (cfg_en) begin
			unique case (cfg_index)
				REG_ACTIVE_SIZE: active_size_q <= cfg_data[5:0];
				REG_MAX_ITER:    max_iter_q    <= cfg_data[15:0];
				REG_TOLERANCE:   tolerance_q   <= cfg_data;
				REG_FIXED_MODE:  fixed_mode_q  <= cfg_data[0];
			endcase
		end
	end

	always_comb begin
		if (active_size_q == 6'd0)
			n_new = CW'(1);
		else if (32'(active_size_q) > MAX_CONSTRAINTS)
			n_new = CW'(MAX_CONSTRAINTS);
		else
			n_new = CW'(active_size_q);
	end

	// memories
	assign m_waddr   = MAW'(32'(in_row) * MAX_CONSTRAINTS + 32'(in_col));
	assign m_raddr   = MAW'(32'(i_q) * MAX_CONSTRAINTS + 32'(j_q));
	assign lam_raddr = (state_q == ST_ROW) ? j_q[IW-1:0] : i_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (in_beat && in_op == OP_WR_MATRIX && 32'(in_row) < MAX_CONSTRAINTS
				&& 32'(in_col) < MAX_CONSTRAINTS)
			matrix_mem[m_waddr] <= in_value;
		h_rd <= matrix_mem[m_raddr];
	end

	always_ff @(posedge clk) begin
		if (in_beat && in_op == OP_WR_OFFSET && 32'(in_row) < MAX_CONSTRAINTS)
			offset_mem[in_row[IW-1:0]] <= in_value;
		off_rd <= offset_mem[i_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (lam_we)
			lambda_mem[lam_waddr] <= lam_wdata;
		lam_rd <= lambda_mem[lam_raddr];
	end

	// datapath
	assign mul_a     = (state_q == ST_FMUL) ? hdiag_q : h_rd;
	assign mul_b     = (state_q == ST_FMUL) ? sum_q : lam_rd;
	assign skip_s1   = diag_s1;
	assign sweep_inc = sweep_q + 16'd1;

	always_comb begin
		nv = fx_scale(prod_s2, FRAC_BITS);
		if (nv[31])
			nv = 32'sd0;
		diff     = (old_q > nv) ? 32'(old_q - nv) : 32'(nv - old_q);
		diff_big = diff > {1'b0, tolerance_q};
	end

	always_comb begin
		lam_we    = 1'b0;
		lam_waddr = i_q[IW-1:0];
		lam_wdata = nv;
		if (state_q == ST_CLR) begin
			lam_we    = 1'b1;
			lam_waddr = j_q[IW-1:0];
			lam_wdata = 32'sd0;
		end else if (state_q == ST_FWR) begin
			lam_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= 64'(mul_a) * 64'(mul_b);
		skip_s2 <= skip_s1;
		if (v_s1 && diag_s1) begin
			hdiag_q <= h_rd;
			old_q   <= lam_rd;
		end
		if (state_q == ST_FADD)
			sum_q <= sat_add(off_rd, acc_q);
		if (state_q == ST_CLR || state_q == ST_FWR)
			acc_q <= 32'sd0;
		else if (v_s2 && !skip_s2)
			acc_q <= sat_add(acc_q, fx_scale(prod_s2, FRAC_BITS));
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			sweep_q <= '0;
			nc_q    <= 1'b0;
			v_s1    <= 1'b0;
			diag_s1 <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			v_s1    <= (state_q == ST_ROW);
			diag_s1 <= (j_q == i_q);
			v_s2    <= v_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat && in_op == OP_SOLVE) begin
						n_q     <= n_new;
						i_q     <= '0;
						j_q     <= '0;
						sweep_q <= '0;
						nc_q    <= 1'b0;
						state_q <= ST_CLR;
					end
				end
				ST_CLR: begin
					if (j_q == n_q - CW'(1)) begin
						j_q     <= '0;
						state_q <= (max_iter_q == 16'd0) ? ST_ORD : ST_ROW;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				ST_ROW: begin
					if (j_q == n_q - CW'(1)) begin
						j_q     <= '0;
						state_q <= ST_DR1;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				ST_DR1:  state_q <= ST_DR2;
				ST_DR2:  state_q <= ST_FADD;
				ST_FADD: state_q <= ST_FMUL;
				ST_FMUL: state_q <= ST_FWR;
				ST_FWR: begin
					if (i_q == n_q - CW'(1)) begin
						i_q     <= '0;
						nc_q    <= 1'b0;
						sweep_q <= sweep_inc;
						if ((!fixed_mode_q && !(nc_q || diff_big)) || sweep_inc >= max_iter_q)
							state_q <= ST_ORD;
						else
							state_q <= ST_ROW;
					end else begin
						i_q     <= i_q + CW'(1);
						nc_q    <= nc_q || diff_big;
						state_q <= ST_ROW;
					end
				end
				ST_ORD: state_q <= ST_OWT;
				ST_OWT: begin
					if (!m_tvalid || m_tready) begin
						if (i_q == n_q - CW'(1)) begin
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + CW'(1);
							state_q <= ST_ORD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_OWT && (!m_tvalid || m_tready)) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OWT && (!m_tvalid || m_tready)) begin
			m_tdata <= {4'd0, sweep_q, lam_rd[30:0], 5'(i_q)};
			m_tlast <= (i_q == n_q - CW'(1));
		end
	end

endmodule

// ===== src/hqp_checker.sv =====
// port-level checker of the hildreth qp dual solver, bound to the top level
`include "hildreth_qp_dual_solver_unit_defines.svh"
module hqp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        m_tlast
);

	logic solve_beat, last_beat, out_stall;

	assign solve_beat = s_tvalid && s_tready && s_tuser == hqp_pkg::OP_SOLVE;
	assign last_beat  = m_tvalid && m_tready && m_tlast;
	assign out_stall  = m_tvalid && !m_tready;

	`HQP_ASSERT_NEXT(a_solve_stalls, clk, arst_n, solve_beat, !s_tready, "input ready after solve beat")
	`HQP_ASSERT_NEXT(a_last_ends, clk, arst_n, last_beat, !m_tvalid, "result beat after last")
	`HQP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_tvalid && $stable(m_tdata), "stalled result changed")
	`HQP_ASSERT_NOW(a_busy_quiet, clk, arst_n, m_tvalid && !s_tready && !$past(m_tvalid), !m_tlast || m_tdata[4:0] != 5'd0 || !m_tvalid, "last beat at index zero while busy")

endmodule

bind hildreth_qp_dual_solver_unit hqp_checker u_hqp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
